[rtl/lir_pkg.sv]
`default_nettype none
package lir_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int PH_W        = FRAC_BITS + 5;

  localparam logic [PH_W-1:0] PH_ONE    = PH_W'(1) << FRAC_BITS;
  localparam logic [PH_W-1:0] RATIO_MIN = PH_W'(1) << (FRAC_BITS - 6);
  localparam logic [PH_W-1:0] RATIO_MAX = PH_W'(1) << (FRAC_BITS + 4);

  // request queue between front and back, power of two
  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic [1:0] {
    KIND_LOAD_ZERO, // block start: clear phase, hold sample
    KIND_LOAD,      // first sample, nothing held yet
    KIND_RUN        // interpolate against held sample
  } lir_kind_t;

  typedef struct packed {
    lir_kind_t               kind;
    logic [SAMPLE_BITS-1:0]  sample;
  } lir_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lir_qstat_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lir_state_t;

endpackage
`default_nettype wire

[rtl/linear_interp_resampler.sv]
// Linear interpolation resampler.
// Input channel: in_valid / in_stall with in_sample_in (signed Q1.15) and
// in_block_start. A request is taken when in_valid is high and in_stall low.
// A block-start request clears the read phase and only stores the sample;
// the first request after reset only stores its sample.
// Other requests emit 0 to 64 results on out_valid / out_stall, each
// out_sample_out = held + floor((new - held) * phase), out_run_last marking
// the last result of that request.
// Config: cfg_wr_en with cfg_step_ratio (unsigned Q5.16), clamped to
// 1/64 .. 16.0, reset value 1.0. Write only while the block is idle.
// A taken request is written to the request queue; the back end pops it and,
// in its run state, writes each result to the output register. A request
// occupies the back end for its pop and its N results, the single multiplier
// emitting one result per cycle unless out_stall is high. A 2-deep request
// queue lets the front keep taking requests meanwhile. out_stall holds the
// output register; the back end waits and the queue fills, after which in_stall rises.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid and
// clears phase and held sample.
`default_nettype none
module linear_interp_resampler import lir_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [PH_W-1:0]        cfg_step_ratio,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_in,
  input  wire logic                   in_block_start,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [SAMPLE_BITS-1:0]      out_sample_out,
  output logic                        out_run_last
);

  lir_qstat_t q_stat;
  lir_req_t   q_wdata;
  lir_req_t   q_rdata;
  logic       q_push;
  logic       q_pop;

  // front: takes requests, tags them by kind
  lir_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_block_start (in_block_start),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  lir_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: phase stepping and interpolation, one result per cycle unless stalled
  lir_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_step_ratio (cfg_step_ratio),
    .q_stat         (q_stat),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_run_last   (out_run_last)
  );

endmodule
`default_nettype wire

[rtl/lir_front.sv]
`default_nettype none
module lir_front import lir_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_in,
  input  wire logic                   in_block_start,
  input  wire lir_qstat_t             q_stat,
  output logic                        q_push,
  output lir_req_t                    q_wdata
);

  logic have_r;
  logic have_nxt;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    q_wdata.sample = in_sample_in;
    if (in_block_start) begin
      q_wdata.kind = KIND_LOAD_ZERO;
    end else if (!have_r) begin
      q_wdata.kind = KIND_LOAD;
    end else begin
      q_wdata.kind = KIND_RUN;
    end
  end

  // any accepted request leaves a sample held
  assign have_nxt = have_r || q_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/lir_fifo.sv]
`default_nettype none
module lir_fifo import lir_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire lir_req_t wdata,
  input  wire logic     pop,
  output lir_req_t      rdata,
  output lir_qstat_t    stat
);

  lir_req_t       mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/lir_back.sv]
`default_nettype none
module lir_back import lir_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [PH_W-1:0]        cfg_step_ratio,
  input  wire lir_qstat_t             q_stat,
  input  wire lir_req_t               q_rdata,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [SAMPLE_BITS-1:0]      out_sample_out,
  output logic                        out_run_last
);

  lir_state_t state_r, state_nxt;

  logic [PH_W-1:0]        ratio_r, ratio_nxt;
  logic [PH_W-1:0]        phase_r, phase_nxt;
  logic [SAMPLE_BITS-1:0] held_r, held_nxt;
  logic [SAMPLE_BITS-1:0] cur_r, cur_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                               can_emit;
  logic                               phase_lt_one;
  logic [PH_W-1:0]                    phase_sum;
  logic                               run_done;
  logic signed [SAMPLE_BITS:0]        diff;
  logic signed [SAMPLE_BITS+FRAC_BITS+1:0] prod;
  logic signed [SAMPLE_BITS+FRAC_BITS+1:0] prod_sh;
  logic [SAMPLE_BITS-1:0]             interp;

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_run_last   = out_last_r;

  assign can_emit     = !out_valid_r || !out_stall;
  assign phase_lt_one = (phase_r[PH_W-1:FRAC_BITS] == '0);
  assign q_pop        = (state_r == ST_IDLE) && !q_stat.empty;
  assign phase_sum    = phase_r + ratio_r;
  assign run_done     = (phase_sum >= PH_ONE);

  // held + floor(diff * frac / 1.0); only the low sample bits survive
  assign diff    = $signed({cur_r[SAMPLE_BITS-1], cur_r})
                 - $signed({held_r[SAMPLE_BITS-1], held_r});
  assign prod    = diff * $signed({1'b0, phase_r[FRAC_BITS-1:0]});
  assign prod_sh = prod >>> FRAC_BITS;
  assign interp  = held_r + prod_sh[SAMPLE_BITS-1:0];

  // clamp the written ratio to its legal range
  always_comb begin
    ratio_nxt = ratio_r;
    if (cfg_wr_en) begin
      if (cfg_step_ratio < RATIO_MIN) begin
        ratio_nxt = RATIO_MIN;
      end else if (cfg_step_ratio > RATIO_MAX) begin
        ratio_nxt = RATIO_MAX;
      end else begin
        ratio_nxt = cfg_step_ratio;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop && q_rdata.kind == KIND_RUN && phase_lt_one) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (can_emit && run_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    held_nxt       = held_r;
    cur_nxt        = cur_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_rdata.kind)
            KIND_LOAD_ZERO: begin
              phase_nxt = '0;
              held_nxt  = q_rdata.sample;
            end
            KIND_LOAD: begin
              held_nxt = q_rdata.sample;
            end
            KIND_RUN: begin
              if (phase_lt_one) begin
                cur_nxt = q_rdata.sample;
              end else begin
                // already past this input: skip it
                phase_nxt = phase_r - PH_ONE;
                held_nxt  = q_rdata.sample;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = interp;
          out_last_nxt   = run_done;
          if (run_done) begin
            phase_nxt = phase_sum - PH_ONE;
            held_nxt  = cur_r;
          end else begin
            phase_nxt = phase_sum;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ratio_r     <= PH_ONE;
      phase_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ratio_r     <= ratio_nxt;
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
`default_nettype wire

[rtl/lir_checker.sv]
`default_nettype none
module lir_checker import lir_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [SAMPLE_BITS-1:0] out_sample_out,
  input wire logic                   out_run_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_sample_out) && $stable(out_run_last))
    else $error("stalled result changed");

  // reset empties the queue and the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out),
  .out_run_last   (out_run_last)
);
`default_nettype wire

[test/tb_linear_interp_resampler.sv]
`default_nettype none
module tb_linear_interp_resampler;
  import lir_pkg::*;

  // timeout, in clocks; worst case is far below this
  localparam int CYCLE_LIMIT = 1_500_000;
  // clocks to let zero-result requests clear the request queue
  localparam int SETTLE      = 20;
  // clocks to watch for stray results at the end
  localparam int TAIL        = 100;
  localparam int N_DIR       = 32;
  localparam int N_PHASE     = 6;
  localparam int PHASE_REQS  = 35;
  localparam int MAX_RUN     = 64;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;
  // how a directed row is checked: predictor, no result, or one typed result
  typedef enum logic [1:0] { CHK_PRED, CHK_NONE, CHK_ONE } row_chk_t;

  typedef struct {
    row_kind_t              kind;
    logic [PH_W-1:0]        ratio;
    logic [SAMPLE_BITS-1:0] smp;
    logic                   start;
    row_chk_t               chk;
    logic [SAMPLE_BITS-1:0] typed_smp;
  } dir_row_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] smp;
    logic                   last;
  } interp_out_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [PH_W-1:0]        cfg_step_ratio = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic                   in_block_start = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SAMPLE_BITS-1:0] out_sample_out;
  logic                   out_run_last;

  linear_interp_resampler u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_step_ratio (cfg_step_ratio),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_block_start (in_block_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_run_last   (out_run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Interpolator shadow state, stepped once per accepted request
  // ---------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] pred_held   = '0;
  logic [PH_W-1:0]        pred_phase  = '0;
  logic                   pred_loaded = 1'b0;
  logic [PH_W-1:0]        pred_ratio  = PH_ONE;

  interp_out_t want_q[$];   // results still owed by the block, oldest first
  interp_out_t run_buf[$];  // results of the request just predicted

  int err_count = 0;
  int cycles    = 0;
  bit snd_quiet = 1'b0;
  bit rcv_quiet = 1'b0;

  // Results for one request into run_buf; updates phase and held sample.
  task automatic interp_predict(input logic [SAMPLE_BITS-1:0] smp, input logic start);
    longint          d_l;
    longint          ph_l;
    longint          h_l;
    logic [PH_W-1:0] nxt;
    interp_out_t     r;
    int              n;
    run_buf.delete();
    // block start: phase back to zero, sample held, nothing out
    if (start) begin
      pred_phase  = '0;
      pred_held   = smp;
      pred_loaded = 1'b1;
      return;
    end
    // nothing held yet: hold it, phase untouched
    if (!pred_loaded) begin
      pred_held   = smp;
      pred_loaded = 1'b1;
      return;
    end
    n = 0;
    h_l = longint'($signed(pred_held));
    d_l = longint'($signed(smp)) - h_l;
    // phase >= 1.0 on arrival skips the loop entirely
    while (pred_phase < PH_ONE && n < MAX_RUN) begin
      ph_l   = longint'(pred_phase);
      r.smp  = SAMPLE_BITS'(h_l + ((d_l * ph_l) >>> FRAC_BITS));
      nxt    = pred_phase + pred_ratio;
      r.last = (nxt >= PH_ONE) || (n == MAX_RUN - 1);
      run_buf.push_back(r);
      pred_phase = nxt;
      n++;
    end
    pred_phase = (pred_phase >= PH_ONE) ? pred_phase - PH_ONE : '0;
    pred_held  = smp;
  endtask

  function automatic int unsigned gap_draw(input bit quiet);
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic dir_row_t req_row(input logic [SAMPLE_BITS-1:0] smp, input logic start,
                                       input row_chk_t chk,
                                       input logic [SAMPLE_BITS-1:0] typed_smp);
    dir_row_t r;
    r.kind = ROW_REQ;
    r.ratio = '0;
    r.smp = smp;
    r.start = start;
    r.chk = chk;
    r.typed_smp = typed_smp;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [PH_W-1:0] ratio);
    dir_row_t r;
    r = req_row('0, 1'b0, CHK_NONE, '0);
    r.kind  = ROW_CFG;
    r.ratio = ratio;
    return r;
  endfunction

  // Mix of in-range, clamped-low and fully random ratios.
  function automatic logic [PH_W-1:0] pick_ratio();
    case ($urandom_range(0, 4))
      0:       return PH_W'($urandom_range(0, 1023));
      1:       return PH_W'($urandom);
      2:       return PH_W'($urandom_range(1024, 32'h0_FFFF));
      default: return PH_W'($urandom_range(32'h1_0000, 32'h10_0000));
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return SAMPLE_BITS'($urandom);
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------
  // Returns at the edge where the request was taken.
  task automatic send_req(input logic [SAMPLE_BITS-1:0] smp, input logic start);
    int unsigned gap;
    gap = gap_draw(snd_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_in   <= smp;
    in_block_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic push_run();
    foreach (run_buf[k]) want_q.push_back(run_buf[k]);
  endtask

  // Stop sending and wait for every owed result.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
  endtask

  // Ratio writes only with the block idle; zero-result requests may still be
  // in flight after the last result, hence the settle time.
  task automatic write_ratio(input logic [PH_W-1:0] v);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en      <= 1'b1;
    cfg_step_ratio <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (v < RATIO_MIN)
      pred_ratio = RATIO_MIN;
    else if (v > RATIO_MAX)
      pred_ratio = RATIO_MAX;
    else
      pred_ratio = v;
  endtask

  dir_row_t dir_rows [N_DIR];

  initial begin
    logic [SAMPLE_BITS-1:0] smp;
    logic                   st;
    interp_out_t            one;

    // Ratio 1.0 after reset: each request gives one result equal to the
    // held sample, so those rows carry their result typed in.
    dir_rows = '{
      req_row(16'h7FFF, 1'b0, CHK_NONE, 16'h0000), // first sample, nothing held
      req_row(16'h8000, 1'b0, CHK_ONE,  16'h7FFF),
      req_row(16'h0000, 1'b0, CHK_ONE,  16'h8000),
      req_row(16'h1234, 1'b1, CHK_NONE, 16'h0000), // block start
      req_row(16'h5555, 1'b0, CHK_ONE,  16'h1234),
      cfg_row(21'h000000),                         // below min, clamps to 1/64
      req_row(16'h8000, 1'b0, CHK_PRED, 16'h0000), // 64-result run
      req_row(16'h7FFF, 1'b0, CHK_PRED, 16'h0000),
      cfg_row(21'h1FFFFF),                         // above max, clamps to 16.0
      req_row(16'h0100, 1'b0, CHK_ONE,  16'h7FFF),
      req_row(16'hFF00, 1'b0, CHK_NONE, 16'h0000), // phase 15.0 on arrival
      req_row(16'h0000, 1'b1, CHK_NONE, 16'h0000),
      req_row(16'h4000, 1'b0, CHK_ONE,  16'h0000),
      cfg_row(21'h004000),                         // 0.25
      req_row(16'h7FFF, 1'b1, CHK_NONE, 16'h0000),
      req_row(16'h8000, 1'b0, CHK_PRED, 16'h0000),
      req_row(16'h7FFF, 1'b0, CHK_PRED, 16'h0000),
      cfg_row(21'h018000),                         // 1.5
      req_row(16'h8001, 1'b0, CHK_PRED, 16'h0000),
      req_row(16'h7FFE, 1'b0, CHK_PRED, 16'h0000),
      req_row(16'h0001, 1'b0, CHK_PRED, 16'h0000),
      cfg_row(21'h000400),                         // exactly 1/64
      req_row(16'h0000, 1'b1, CHK_NONE, 16'h0000),
      req_row(16'hFFFF, 1'b0, CHK_PRED, 16'h0000),
      cfg_row(21'h100000),                         // exactly 16.0
      req_row(16'h0000, 1'b0, CHK_ONE,  16'hFFFF),
      cfg_row(21'h0003FF),                         // just below min
      req_row(16'h8000, 1'b1, CHK_NONE, 16'h0000),
      req_row(16'h7FFF, 1'b0, CHK_PRED, 16'h0000),
      cfg_row(21'h100001),                         // just above max
      req_row(16'h1111, 1'b0, CHK_PRED, 16'h0000),
      cfg_row(21'h010000)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_ratio(dir_rows[i].ratio);
      end else begin
        send_req(dir_rows[i].smp, dir_rows[i].start);
        interp_predict(dir_rows[i].smp, dir_rows[i].start);
        case (dir_rows[i].chk)
          CHK_PRED: begin
            push_run();
          end
          CHK_ONE: begin
            one.smp  = dir_rows[i].typed_smp;
            one.last = 1'b1;
            want_q.push_back(one);
          end
          default: begin
          end
        endcase
      end
    end

    // random phases, each with its own ratio and idling mode
    for (int ph = 0; ph < N_PHASE; ph++) begin
      write_ratio(pick_ratio());
      snd_quiet = (ph == 2) || ($urandom_range(0, 3) == 0);
      rcv_quiet = (ph == 2) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_REQS; i++) begin
        // sender holds off mid-phase until the block has caught up
        if (ph == 3 && i == PHASE_REQS / 2) drain_results();
        smp = pick_sample();
        st  = ($urandom_range(0, 9) == 0);
        send_req(smp, st);
        interp_predict(smp, st);
        push_run();
      end
    end

    drain_results();
    repeat (TAIL) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: check each taken result, then stall for a drawn count
  // ---------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned rx_wait;
  interp_out_t rx_want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        err_count++;
        $display("%0t: result with nothing owed: sample %h last %b",
                 $time, out_sample_out, out_run_last);
      end else begin
        rx_want = want_q.pop_front();
        if (out_sample_out !== rx_want.smp) begin
          err_count++;
          $display("%0t: sample_out expected %h actual %h",
                   $time, rx_want.smp, out_sample_out);
        end
        if (out_run_last !== rx_want.last) begin
          err_count++;
          $display("%0t: run_last expected %b actual %b",
                   $time, rx_want.last, out_run_last);
        end
      end
      rx_wait = gap_draw(rcv_quiet);
      if (rx_wait != 0) begin
        out_stall  <= 1'b1;
        stall_left <= rx_wait;
      end
    end else if (out_stall) begin
      if (stall_left <= 1) out_stall <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
`default_nettype wire

[sim.f]
rtl/lir_pkg.sv
rtl/lir_front.sv
rtl/lir_fifo.sv
rtl/lir_back.sv
rtl/linear_interp_resampler.sv
rtl/lir_checker.sv
test/tb_linear_interp_resampler.sv
